### hw/rtl/cam_pkg.sv
// ----------------------------------------------------------------------------
// Calibrated analog mapper package
// Widths, codes and item types shared by the mapper, its channels and checker.
// ----------------------------------------------------------------------------
`default_nettype none

package cam_pkg;

    // Converter resolution and derived limits.
    localparam int ADC_BITS = 10;
    localparam logic [ADC_BITS-1:0] ADC_MAX    = ADC_BITS'((2 ** ADC_BITS) - 1);
    localparam logic [ADC_BITS-1:0] ADC_CENTER = ADC_BITS'(((2 ** ADC_BITS) - 1) / 2);

    // Width of the output-side configuration values and of the held value.
    localparam int DATA_W  = 14;
    localparam int VALUE_W = DATA_W + 1;

    // Product of an input distance and an output distance, and the signed
    // width that holds a mapped value before saturation.
    localparam int PROD_W = ADC_BITS + DATA_W;
    localparam int MAP_W  = PROD_W + 2;
    localparam int CNT_W  = $clog2(PROD_W);

    // Configuration port.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_ENABLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_POINT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADSPOT      = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [DATA_W-1:0] RANGE_MAX_RST  = DATA_W'(1023);
    localparam logic [DATA_W-1:0] HYSTERESIS_RST = DATA_W'(1);

    // Item actions.
    localparam logic [1:0] ACT_SAMPLE    = 2'd0;
    localparam logic [1:0] ACT_START_CAL = 2'd1;
    localparam logic [1:0] ACT_STOP_CAL  = 2'd2;
    localparam logic [1:0] ACT_LOAD_CAL  = 2'd3;

    typedef struct packed {
        logic [1:0]          action;
        logic [ADC_BITS-1:0] sample;
        logic [ADC_BITS-1:0] load_min;
        logic [ADC_BITS-1:0] load_max;
        logic [ADC_BITS-1:0] load_center;
    } cam_in_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      changed;
        logic                      calibration_grew;
        logic [ADC_BITS-1:0]       cal_min_out;
        logic [ADC_BITS-1:0]       cal_max_out;
        logic [ADC_BITS-1:0]       cal_center_out;
        logic                      calibrating_out;
    } cam_out_t;

endpackage

`default_nettype wire

### hw/rtl/cam_in_if.sv
// ----------------------------------------------------------------------------
// Calibrated analog mapper input channel
// Valid/ready channel carrying one sample, calibration or load item.
// ----------------------------------------------------------------------------
`default_nettype none

interface cam_in_if import cam_pkg::*; ();

    logic    valid;
    logic    ready;
    cam_in_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);

endinterface

`default_nettype wire

### hw/rtl/cam_out_if.sv
// ----------------------------------------------------------------------------
// Calibrated analog mapper result channel
// Valid/ready channel carrying one result item per input item.
// ----------------------------------------------------------------------------
`default_nettype none

interface cam_out_if import cam_pkg::*; ();

    logic     valid;
    logic     ready;
    cam_out_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);

endinterface

`default_nettype wire

### hw/rtl/calibrated_analog_mapper_core.sv
// ----------------------------------------------------------------------------
// Calibrated analog mapper core
// Min/max calibration of converter samples with a linear or centred mapping,
// deadband and output hysteresis, using a bit-serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on req and each produces exactly one result item on rsp.
//   Action sample maps the reading; start, stop and load only change the
//   stored calibration and report the held value unchanged.
//   The configuration port (cfg_we, cfg_index, cfg_data) is written while
//   the block is idle; writes to unused indexes are ignored.
// Processing steps:
//   A sample item passes segment selection, the multiplier, the restoring
//   divider, which retires one quotient bit a cycle over PROD_W (24) bits,
//   and then deadband, saturation and hysteresis. Its result enters the
//   output register as req.ready returns, so only one item is in work at a
//   time. A zero calibrated span skips the divider. Start, stop and load
//   items go straight to the output step.
// Reset and stalls:
//   Reset restores the configuration defaults, the calibration span 0..1023
//   with centre 511, and a held value of -1. A finished result sits in the
//   output register; if the receiver stalls, the next item is still taken
//   and processed, and waits in its last step until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module calibrated_analog_mapper_core import cam_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,
    cam_in_if.sink               req,
    cam_out_if.source            rsp,
    input  wire                  cfg_we,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [DATA_W-1:0]     cfg_data
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_POST  = 3'd4;
    localparam logic [2:0] S_CLAMP = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    // Configuration registers.
    logic [DATA_W-1:0] range_max_reg;
    logic              center_enable_reg;
    logic [DATA_W-1:0] center_point_reg;
    logic [DATA_W-1:0] hysteresis_reg;
    logic [DATA_W-1:0] deadspot_reg;

    // Calibration and output state.
    logic [ADC_BITS-1:0]       cal_min_reg, cal_min_next;
    logic [ADC_BITS-1:0]       cal_max_reg, cal_max_next;
    logic [ADC_BITS-1:0]       cal_center_reg, cal_center_next;
    logic                      calibrating_reg, calibrating_next;
    logic signed [VALUE_W-1:0] held_reg;

    // Sequencer and per-item working registers.
    logic [2:0]          state_reg, state_next;
    logic                is_sample_reg;
    logic                grew_reg, grew_next;
    logic [ADC_BITS-1:0] x_reg;
    logic [ADC_BITS-1:0] dx_mag_reg;
    logic [DATA_W-1:0]   dy_mag_reg;
    logic [ADC_BITS-1:0] div_reg;
    logic                span_zero_reg;
    logic                neg_reg;
    logic [DATA_W-1:0]   lo_reg;
    logic [ADC_BITS-1:0] rem_reg;
    logic [PROD_W-1:0]   dq_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic signed [MAP_W-1:0] mapped_reg;
    logic [DATA_W-1:0]   clamped_reg;

    // Output register.
    logic     rsp_valid_reg;
    cam_out_t rsp_item_reg;

    logic accept;
    logic out_free;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.item  = rsp_item_reg;

    // ------------------------------------------------------------------
    // Configuration writes.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_max_reg     <= RANGE_MAX_RST;
            center_enable_reg <= 1'b0;
            center_point_reg  <= '0;
            hysteresis_reg    <= HYSTERESIS_RST;
            deadspot_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RANGE_MAX:     range_max_reg     <= cfg_data;
                CFG_CENTER_ENABLE: center_enable_reg <= cfg_data[0];
                CFG_CENTER_POINT:  center_point_reg  <= cfg_data;
                CFG_HYSTERESIS:    hysteresis_reg    <= cfg_data;
                CFG_DEADSPOT:      deadspot_reg      <= cfg_data;
                default:           ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Calibration update on acceptance. A sample widens the span first, so
    // the mapping that follows already uses the widened limits.
    // ------------------------------------------------------------------
    always_comb
    begin
        cal_min_next     = cal_min_reg;
        cal_max_next     = cal_max_reg;
        cal_center_next  = cal_center_reg;
        calibrating_next = calibrating_reg;
        grew_next        = 1'b0;
        unique case (req.item.action)
            ACT_SAMPLE:
            begin
                if (calibrating_reg)
                begin
                    if (req.item.sample < cal_min_reg)
                    begin
                        cal_min_next = req.item.sample;
                        grew_next    = 1'b1;
                    end
                    if (req.item.sample > cal_max_reg)
                    begin
                        cal_max_next = req.item.sample;
                        grew_next    = 1'b1;
                    end
                end
            end
            ACT_START_CAL:
            begin
                cal_min_next     = ADC_MAX;
                cal_max_next     = '0;
                cal_center_next  = req.item.sample;
                calibrating_next = 1'b1;
            end
            ACT_STOP_CAL:
            begin
                calibrating_next = 1'b0;
            end
            default:
            begin
                cal_min_next     = req.item.load_min;
                cal_max_next     = req.item.load_max;
                cal_center_next  = req.item.load_center;
                calibrating_next = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Segment selection: input limits a..b map onto output lo..hi.
    // ------------------------------------------------------------------
    logic [ADC_BITS-1:0]     seg_a, seg_b;
    logic [DATA_W-1:0]       seg_lo, seg_hi;
    logic signed [ADC_BITS:0] dx, span;
    logic signed [DATA_W:0]   dy;
    logic [ADC_BITS:0]        dx_abs, span_abs;
    logic [DATA_W:0]          dy_abs;

    always_comb
    begin
        if (center_enable_reg && (x_reg < cal_center_reg))
        begin
            seg_a  = cal_min_reg;
            seg_b  = cal_center_reg;
            seg_lo = '0;
            seg_hi = center_point_reg;
        end
        else if (center_enable_reg)
        begin
            seg_a  = cal_center_reg;
            seg_b  = cal_max_reg;
            seg_lo = center_point_reg;
            seg_hi = range_max_reg;
        end
        else
        begin
            seg_a  = cal_min_reg;
            seg_b  = cal_max_reg;
            seg_lo = '0;
            seg_hi = range_max_reg;
        end
        dx       = $signed({1'b0, x_reg}) - $signed({1'b0, seg_a});
        span     = $signed({1'b0, seg_b}) - $signed({1'b0, seg_a});
        dy       = $signed({1'b0, seg_hi}) - $signed({1'b0, seg_lo});
        dx_abs   = dx[ADC_BITS] ? (~dx + 1'b1) : dx;
        span_abs = span[ADC_BITS] ? (~span + 1'b1) : span;
        dy_abs   = dy[DATA_W] ? (~dy + 1'b1) : dy;
    end

    // ------------------------------------------------------------------
    // One restoring division step: bring in the next dividend bit and
    // subtract the divisor when it fits.
    // ------------------------------------------------------------------
    logic [ADC_BITS:0]   trial;
    logic                fits;
    logic [ADC_BITS:0]   trial_diff;

    always_comb
    begin
        trial      = {rem_reg, dq_reg[PROD_W-1]};
        fits       = (trial >= {1'b0, div_reg});
        trial_diff = trial - {1'b0, div_reg};
    end

    // ------------------------------------------------------------------
    // Signed quotient, offset and deadband.
    // ------------------------------------------------------------------
    logic signed [MAP_W-1:0] quot_mag, quot_signed, mapped_raw, dist_raw, dist_abs;
    logic signed [MAP_W-1:0] center_ext;
    logic                    in_deadband;

    always_comb
    begin
        quot_mag    = $signed({2'b00, dq_reg});
        quot_signed = neg_reg ? -quot_mag : quot_mag;
        mapped_raw  = $signed({{(MAP_W - DATA_W){1'b0}}, lo_reg}) + quot_signed;
        center_ext  = $signed({{(MAP_W - DATA_W){1'b0}}, center_point_reg});
        dist_raw    = mapped_raw - center_ext;
        dist_abs    = dist_raw[MAP_W-1] ? -dist_raw : dist_raw;
        in_deadband = (dist_abs <= $signed({{(MAP_W - DATA_W){1'b0}}, deadspot_reg}));
    end

    // ------------------------------------------------------------------
    // Hysteresis against the held value.
    // ------------------------------------------------------------------
    logic signed [VALUE_W+1:0] held_ext, hyst_ext, cand_ext, band_lo, band_hi;
    logic                      update;

    always_comb
    begin
        held_ext = {{2{held_reg[VALUE_W-1]}}, held_reg};
        hyst_ext = $signed({3'b000, hysteresis_reg});
        cand_ext = $signed({3'b000, clamped_reg});
        band_lo  = held_ext - hyst_ext;
        band_hi  = held_ext + hyst_ext;
        update   = is_sample_reg && ((cand_ext < band_lo) || (cand_ext > band_hi));
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req.item.action == ACT_SAMPLE) ? S_SETUP : S_DONE;
                end
            end
            S_SETUP: state_next = S_MUL;
            S_MUL:   state_next = span_zero_reg ? S_POST : S_DIV;
            S_DIV:
            begin
                if (cnt_reg == CNT_W'(PROD_W - 1))
                begin
                    state_next = S_POST;
                end
            end
            S_POST:  state_next = S_CLAMP;
            S_CLAMP: state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cal_min_reg     <= '0;
            cal_max_reg     <= ADC_MAX;
            cal_center_reg  <= ADC_CENTER;
            calibrating_reg <= 1'b0;
            held_reg        <= '1;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                cal_min_reg     <= cal_min_next;
                cal_max_reg     <= cal_max_next;
                cal_center_reg  <= cal_center_next;
                calibrating_reg <= calibrating_next;
            end
            if ((state_reg == S_DONE) && out_free)
            begin
                rsp_valid_reg <= 1'b1;
                if (update)
                begin
                    held_reg <= $signed({1'b0, clamped_reg});
                end
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers carry no reset; the sequencer qualifies them.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg         <= req.item.sample;
            is_sample_reg <= (req.item.action == ACT_SAMPLE);
            grew_reg      <= grew_next;
        end

        if (state_reg == S_SETUP)
        begin
            dx_mag_reg    <= dx_abs[ADC_BITS-1:0];
            dy_mag_reg    <= dy_abs[DATA_W-1:0];
            div_reg       <= span_abs[ADC_BITS-1:0];
            span_zero_reg <= (span == '0);
            neg_reg       <= dx[ADC_BITS] ^ dy[DATA_W] ^ span[ADC_BITS];
            lo_reg        <= seg_lo;
        end

        if (state_reg == S_MUL)
        begin
            // A zero span maps to the segment's lower output, so the
            // quotient is forced to zero.
            dq_reg  <= span_zero_reg ? '0 : (dx_mag_reg * dy_mag_reg);
            rem_reg <= '0;
            cnt_reg <= '0;
        end

        if (state_reg == S_DIV)
        begin
            rem_reg <= fits ? trial_diff[ADC_BITS-1:0] : trial[ADC_BITS-1:0];
            dq_reg  <= {dq_reg[PROD_W-2:0], fits};
            cnt_reg <= cnt_reg + 1'b1;
        end

        if (state_reg == S_POST)
        begin
            mapped_reg <= (center_enable_reg && in_deadband) ? center_ext : mapped_raw;
        end

        if (state_reg == S_CLAMP)
        begin
            if (mapped_reg[MAP_W-1])
            begin
                clamped_reg <= '0;
            end
            else if (mapped_reg > $signed({{(MAP_W - DATA_W){1'b0}}, range_max_reg}))
            begin
                clamped_reg <= range_max_reg;
            end
            else
            begin
                clamped_reg <= mapped_reg[DATA_W-1:0];
            end
        end

        if ((state_reg == S_DONE) && out_free)
        begin
            rsp_item_reg.value            <= update ? $signed({1'b0, clamped_reg}) : held_reg;
            rsp_item_reg.changed          <= update;
            rsp_item_reg.calibration_grew <= grew_reg;
            rsp_item_reg.cal_min_out      <= cal_min_reg;
            rsp_item_reg.cal_max_out      <= cal_max_reg;
            rsp_item_reg.cal_center_out   <= cal_center_reg;
            rsp_item_reg.calibrating_out  <= calibrating_reg;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/cam_checker.sv
// ----------------------------------------------------------------------------
// Calibrated analog mapper checker
// Port-level assertions on the mapper core, attached by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module cam_checker import cam_pkg::*;
(
    input wire                      clk,
    input wire                      rst_n,
    input wire                      req_valid,
    input wire                      req_ready,
    input wire                      rsp_valid,
    input wire                      rsp_ready,
    input wire signed [VALUE_W-1:0] rsp_value,
    input wire                      rsp_changed,
    input wire                      rsp_grew,
    input wire                      rsp_calibrating
);

    // A stalled result must hold its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_value)))
        else $error("result value changed while stalled");

    // Only one item is in work at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("input ready right after an accepted item");

    // An update always lands inside the output range, never at the -1 marker.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_changed) |-> (rsp_value >= 0))
        else $error("updated value is negative");

    // The span only widens while calibration is running.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_grew) |-> rsp_calibrating)
        else $error("calibration grew while not calibrating");

endmodule

bind calibrated_analog_mapper_core cam_checker u_cam_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_value       (rsp.item.value),
    .rsp_changed     (rsp.item.changed),
    .rsp_grew        (rsp.item.calibration_grew),
    .rsp_calibrating (rsp.item.calibrating_out)
);

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Calibrated analog mapper core testbench
// Drives sample, calibration and load items through the mapper under changing
// register settings and checks every result item against a local model of
// the calibration tracking, span mapping, deadband and hysteresis.
// ----------------------------------------------------------------------------

module testbench;

    import cam_pkg::*;

    // No handshake on either channel for this many cycles ends the run. The
    // limit sits well above the slowest item in the block plus the longest
    // receiver stall and sender gap, so it leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 1000;

    // Cycles allowed for stray results after the last expected one.
    localparam int SETTLE_CYCLES = 40;

    // Items per random register setting, and the number of such settings.
    localparam int PHASE_ITEMS = 56;
    localparam int PHASE_COUNT = 8;

    // An index that selects no register; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef enum logic { ROW_ITEM, ROW_REG } row_kind_t;

    // One row of the directed table: either an item, optionally with its
    // result typed in, or a register write made while the block is idle.
    typedef struct {
        row_kind_t              kind;
        cam_in_t                item;
        bit                     typed;
        cam_out_t               want;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [DATA_W-1:0]      reg_data;
    } stim_row_t;

    // Receiver behaviour: always ready, mostly ready, coin toss, or long
    // blocked stretches.
    typedef enum int { SINK_FREE, SINK_SPARSE, SINK_COIN, SINK_BLOCKED } sink_mode_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [DATA_W-1:0]      cfg_data;

    cam_in_if  req_ch ();
    cam_out_if rsp_ch ();

    calibrated_analog_mapper_core DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Model state. Everything is held as a signed 64-bit integer so that the
    // signed map arithmetic never mixes with unsigned vectors.
    // ------------------------------------------------------------------------
    longint out_span   = 1023;     // largest output value
    longint centred    = 0;        // piecewise mapping around the centre
    longint out_center = 0;        // output value of the calibrated centre
    longint hyst_band  = 1;        // change needed before the output moves
    longint dead_band  = 0;        // snap distance around the output centre

    longint trk_min    = 0;
    longint trk_max    = 1023;
    longint trk_center = 511;
    longint tracking   = 0;
    longint held_out   = -1;

    cam_out_t  pending_results[$];
    stim_row_t directed_rows[$];

    int mismatches     = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int samples_mapped = 0;
    int held_updates   = 0;
    int span_widenings = 0;
    int settings_used  = 0;
    int burst_left     = 0;
    int quiet_cycles   = 0;
    int sink_tick      = 0;

    sink_mode_t sink_mode = SINK_FREE;
    cam_out_t   oldest;

    // ------------------------------------------------------------------------
    // Clock: 2 ns period.
    // ------------------------------------------------------------------------
    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Model of the mapper.
    // ------------------------------------------------------------------------

    // Maps x from the span a..b onto lo..hi, truncating toward zero. A zero
    // span yields the output minimum of the segment.
    function automatic longint scale_span(longint x, longint a, longint b,
                                          longint lo, longint hi);
        if (b == a)
            return lo;
        return lo + ((x - a) * (hi - lo)) / (b - a);
    endfunction

    // Applies one accepted item to the model state and returns the result
    // item the block should produce for it.
    function automatic cam_out_t predict_mapper_item(cam_in_t it);
        cam_out_t r;
        longint   x;
        longint   m;
        longint   dev;
        bit       grew;
        bit       chg;

        x    = it.sample;
        grew = 1'b0;
        chg  = 1'b0;

        case (it.action)
            ACT_SAMPLE:
            begin
                // While calibrating, the reading first widens the span.
                if (tracking != 0)
                begin
                    if (x < trk_min)
                    begin
                        trk_min = x;
                        grew    = 1'b1;
                    end
                    if (x > trk_max)
                    begin
                        trk_max = x;
                        grew    = 1'b1;
                    end
                end

                if (centred != 0)
                begin
                    // Readings below the centre use the lower segment; the
                    // centre itself and above use the upper one.
                    if (x < trk_center)
                        m = scale_span(x, trk_min, trk_center, 0, out_center);
                    else
                        m = scale_span(x, trk_center, trk_max, out_center, out_span);
                    dev = m - out_center;
                    if (dev < 0)
                        dev = -dev;
                    if (dev <= dead_band)
                        m = out_center;
                end
                else
                begin
                    m = scale_span(x, trk_min, trk_max, 0, out_span);
                end

                // Saturation comes after the deadband, so a centre above the
                // range still ends at the range maximum.
                if (m < 0)
                    m = 0;
                if (m > out_span)
                    m = out_span;

                if (m < held_out - hyst_band || m > held_out + hyst_band)
                begin
                    held_out = m;
                    chg      = 1'b1;
                end

                samples_mapped++;
                if (chg)
                    held_updates++;
                if (grew)
                    span_widenings++;
            end
            ACT_START_CAL:
            begin
                trk_min    = ADC_MAX;
                trk_max    = 0;
                trk_center = x;
                tracking   = 1;
            end
            ACT_STOP_CAL:
            begin
                tracking = 0;
            end
            default:
            begin
                trk_min    = it.load_min;
                trk_max    = it.load_max;
                trk_center = it.load_center;
                tracking   = 0;
            end
        endcase

        r.value            = VALUE_W'(held_out);
        r.changed          = chg;
        r.calibration_grew = grew;
        r.cal_min_out      = ADC_BITS'(trk_min);
        r.cal_max_out      = ADC_BITS'(trk_max);
        r.cal_center_out   = ADC_BITS'(trk_center);
        r.calibrating_out  = (tracking != 0);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table helpers.
    // ------------------------------------------------------------------------
    function automatic stim_row_t item_row(logic [1:0] act, int smp, int lmin = 0,
                                           int lmax = 0, int lcen = 0);
        stim_row_t r;
        r.kind             = ROW_ITEM;
        r.item.action      = act;
        r.item.sample      = ADC_BITS'(smp);
        r.item.load_min    = ADC_BITS'(lmin);
        r.item.load_max    = ADC_BITS'(lmax);
        r.item.load_center = ADC_BITS'(lcen);
        r.typed            = 1'b0;
        r.want             = '0;
        r.reg_idx          = '0;
        r.reg_data         = '0;
        return r;
    endfunction

    function automatic stim_row_t typed_row(stim_row_t r, int val, bit chg, bit grew,
                                            int mn, int mx, int cen, bit cal);
        r.typed                 = 1'b1;
        r.want.value            = VALUE_W'(val);
        r.want.changed          = chg;
        r.want.calibration_grew = grew;
        r.want.cal_min_out      = ADC_BITS'(mn);
        r.want.cal_max_out      = ADC_BITS'(mx);
        r.want.cal_center_out   = ADC_BITS'(cen);
        r.want.calibrating_out  = cal;
        return r;
    endfunction

    function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx, int data);
        stim_row_t r;
        r          = item_row(ACT_SAMPLE, 0);
        r.kind     = ROW_REG;
        r.reg_idx  = idx;
        r.reg_data = DATA_W'(data);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Random item content.
    // ------------------------------------------------------------------------

    // Readings favour the converter extremes and the neighbourhood of the
    // calibrated centre, where the deadband and the segment switch live.
    function automatic logic [ADC_BITS-1:0] pick_reading();
        longint v;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ADC_MAX;
            2, 3:
            begin
                v = trk_center + longint'($urandom_range(0, 16)) - 8;
                if (v < 0)
                    v = 0;
                if (v > ADC_MAX)
                    v = ADC_MAX;
                return ADC_BITS'(v);
            end
            default: return ADC_BITS'($urandom);
        endcase
    endfunction

    // Load fields always carry random content, even where the action
    // ignores them, so that every input bit is exercised.
    function automatic cam_in_t make_item(logic [1:0] act, logic [ADC_BITS-1:0] smp);
        cam_in_t it;
        it.action      = act;
        it.sample      = smp;
        it.load_min    = ADC_BITS'($urandom);
        it.load_max    = ADC_BITS'($urandom);
        it.load_center = ADC_BITS'($urandom);
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Request side: items are sent in bursts with random gaps between them.
    // ------------------------------------------------------------------------
    task automatic send_item(cam_in_t it, bit typed = 1'b0, cam_out_t want = '0);
        cam_out_t predicted;
        int       gap;

        @(negedge clk);
        req_ch.valid = 1'b1;
        req_ch.item  = it;
        do
            @(posedge clk);
        while (!req_ch.ready);

        items_sent++;
        predicted = predict_mapper_item(it);
        if (typed)
            pending_results.push_back(want);
        else
            pending_results.push_back(predicted);

        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            req_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
            // Now and then a long burst with no idling at all.
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // Stops sending and waits until every outstanding result has arrived,
    // leaving the block idle for register writes.
    task automatic wait_idle();
        if (req_ch.valid)
        begin
            @(negedge clk);
            req_ch.valid = 1'b0;
        end
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we    = 1'b0;

        case (idx)
            CFG_RANGE_MAX:     out_span   = data;
            CFG_CENTER_ENABLE: centred    = data[0];
            CFG_CENTER_POINT:  out_center = data;
            CFG_HYSTERESIS:    hyst_band  = data;
            CFG_DEADSPOT:      dead_band  = data;
            default: ;
        endcase
    endtask

    // Writes a full register setting. The centre enable carries random upper
    // bits, which the block must ignore, and the unused index gets junk.
    task automatic apply_setting(int span, bit centre_on, int centre, int hyst, int dead);
        logic [DATA_W-1:0] enable_word;

        wait_idle();
        enable_word    = DATA_W'($urandom);
        enable_word[0] = centre_on;
        write_reg(CFG_RANGE_MAX, DATA_W'(span));
        write_reg(CFG_CENTER_ENABLE, enable_word);
        write_reg(CFG_CENTER_POINT, DATA_W'(centre));
        write_reg(CFG_HYSTERESIS, DATA_W'(hyst));
        write_reg(CFG_DEADSPOT, DATA_W'(dead));
        write_reg(CFG_UNUSED, DATA_W'($urandom));
        settings_used++;
    endtask

    // Random traffic for one register setting. Most of it is whole
    // calibration sessions (start, samples, stop, more samples) with random
    // readings; the rest is calibration loads and loose random items.
    task automatic run_random_traffic(int budget);
        int first;
        int n;

        first = items_sent;
        while (items_sent - first < budget)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    send_item(make_item(ACT_START_CAL, pick_reading()));
                    n = $urandom_range(2, 24);
                    repeat (n) send_item(make_item(ACT_SAMPLE, pick_reading()));
                    send_item(make_item(ACT_STOP_CAL, ADC_BITS'($urandom)));
                    n = $urandom_range(0, 8);
                    repeat (n) send_item(make_item(ACT_SAMPLE, pick_reading()));
                end
                6, 7:
                begin
                    send_item(make_item(ACT_LOAD_CAL, ADC_BITS'($urandom)));
                    n = $urandom_range(1, 10);
                    repeat (n) send_item(make_item(ACT_SAMPLE, pick_reading()));
                end
                default:
                begin
                    n = $urandom_range(1, 4);
                    repeat (n)
                        send_item(make_item(2'($urandom_range(0, 3)), ADC_BITS'($urandom)));
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: the receiver stalls on its own pattern, which periodically
    // draws a new mode at random.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        sink_tick++;
        if (sink_tick % 150 == 0)
            sink_mode = sink_mode_t'($urandom_range(0, 3));
        case (sink_mode)
            SINK_FREE:    rsp_ch.ready = 1'b1;
            SINK_SPARSE:  rsp_ch.ready = (sink_tick % 5 != 0);
            SINK_COIN:    rsp_ch.ready = 1'($urandom_range(0, 1));
            default:      rsp_ch.ready = (sink_tick % 64) >= 40;
        endcase
    end

    // Prints one line per mismatch and keeps count.
    task automatic report_mismatch(string msg);
        mismatches++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // Each accepted result item is compared with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                report_mismatch("result item arrived with nothing expected");
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (rsp_ch.item.value !== oldest.value)
                    report_mismatch($sformatf("value %0d, expected %0d",
                                              rsp_ch.item.value, oldest.value));
                if (rsp_ch.item.changed !== oldest.changed)
                    report_mismatch($sformatf("changed %0b, expected %0b",
                                              rsp_ch.item.changed, oldest.changed));
                if (rsp_ch.item.calibration_grew !== oldest.calibration_grew)
                    report_mismatch($sformatf("calibration_grew %0b, expected %0b",
                                              rsp_ch.item.calibration_grew,
                                              oldest.calibration_grew));
                if (rsp_ch.item.cal_min_out !== oldest.cal_min_out)
                    report_mismatch($sformatf("cal_min_out %0d, expected %0d",
                                              rsp_ch.item.cal_min_out, oldest.cal_min_out));
                if (rsp_ch.item.cal_max_out !== oldest.cal_max_out)
                    report_mismatch($sformatf("cal_max_out %0d, expected %0d",
                                              rsp_ch.item.cal_max_out, oldest.cal_max_out));
                if (rsp_ch.item.cal_center_out !== oldest.cal_center_out)
                    report_mismatch($sformatf("cal_center_out %0d, expected %0d",
                                              rsp_ch.item.cal_center_out,
                                              oldest.cal_center_out));
                if (rsp_ch.item.calibrating_out !== oldest.calibrating_out)
                    report_mismatch($sformatf("calibrating_out %0b, expected %0b",
                                              rsp_ch.item.calibrating_out,
                                              oldest.calibrating_out));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: counts cycles in which neither channel completes a handshake.
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Watchdog expired after %0d quiet cycles", WATCHDOG_LIMIT);
        $display("calibrated_analog_mapper_core verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin : main_sequence
        int phase;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        req_ch.valid = 1'b0;
        req_ch.item  = '0;
        rsp_ch.ready = 1'b0;

        // Directed part. With the reset span 0..1023 and range 1023 the
        // linear map is the identity, so the first results can be typed in.
        // The first sample maps to 0, which is within the hysteresis of the
        // initial held value of -1, so the output does not move yet.
        directed_rows.push_back(typed_row(item_row(ACT_SAMPLE, 0),
                                          -1, 0, 0, 0, 1023, 511, 0));
        directed_rows.push_back(typed_row(item_row(ACT_SAMPLE, 1023),
                                          1023, 1, 0, 0, 1023, 511, 0));
        directed_rows.push_back(typed_row(item_row(ACT_SAMPLE, 0),
                                          0, 1, 0, 0, 1023, 511, 0));
        directed_rows.push_back(item_row(ACT_SAMPLE, 512));
        // A load with equal minimum and maximum gives a zero span, which
        // maps everything to the output minimum.
        directed_rows.push_back(typed_row(item_row(ACT_LOAD_CAL, 0, 100, 100, 100),
                                          512, 0, 0, 100, 100, 100, 0));
        directed_rows.push_back(typed_row(item_row(ACT_SAMPLE, 300),
                                          0, 1, 0, 100, 100, 100, 0));
        // Starting calibration inverts the span and takes the reading as the
        // centre; the first tracked sample closes it down to a single point.
        directed_rows.push_back(typed_row(item_row(ACT_START_CAL, 600),
                                          0, 0, 0, 1023, 0, 600, 1));
        directed_rows.push_back(typed_row(item_row(ACT_SAMPLE, 700),
                                          0, 0, 1, 700, 700, 600, 1));
        directed_rows.push_back(item_row(ACT_SAMPLE, 200));
        directed_rows.push_back(item_row(ACT_SAMPLE, 1023));
        directed_rows.push_back(item_row(ACT_SAMPLE, 0));
        directed_rows.push_back(item_row(ACT_STOP_CAL, 0));
        // Inverted span loaded directly: the signed formula runs unchanged.
        directed_rows.push_back(item_row(ACT_LOAD_CAL, 0, 1023, 0, 511));
        directed_rows.push_back(item_row(ACT_SAMPLE, 500));
        directed_rows.push_back(item_row(ACT_SAMPLE, 1023));
        // A write to an unused index must leave everything as it was.
        directed_rows.push_back(reg_row(CFG_UNUSED, 16383));
        // Piecewise mapping with a deadband of 10 around an output centre
        // of 400 and no hysteresis.
        directed_rows.push_back(reg_row(CFG_CENTER_ENABLE, 1));
        directed_rows.push_back(reg_row(CFG_CENTER_POINT, 400));
        directed_rows.push_back(reg_row(CFG_DEADSPOT, 10));
        directed_rows.push_back(reg_row(CFG_HYSTERESIS, 0));
        directed_rows.push_back(item_row(ACT_LOAD_CAL, 0, 0, 1000, 500));
        directed_rows.push_back(item_row(ACT_SAMPLE, 250));
        directed_rows.push_back(item_row(ACT_SAMPLE, 505));
        directed_rows.push_back(item_row(ACT_SAMPLE, 600));
        directed_rows.push_back(item_row(ACT_SAMPLE, 1023));
        // An output centre above the range is clamped after the deadband.
        directed_rows.push_back(reg_row(CFG_CENTER_POINT, 16383));
        directed_rows.push_back(item_row(ACT_SAMPLE, 500));
        // Widest range, and zero spans on both sides of the centre.
        directed_rows.push_back(reg_row(CFG_RANGE_MAX, 16383));
        directed_rows.push_back(reg_row(CFG_CENTER_POINT, 0));
        directed_rows.push_back(reg_row(CFG_DEADSPOT, 0));
        directed_rows.push_back(item_row(ACT_LOAD_CAL, 0, 500, 500, 500));
        directed_rows.push_back(item_row(ACT_SAMPLE, 500));
        directed_rows.push_back(item_row(ACT_SAMPLE, 499));
        directed_rows.push_back(item_row(ACT_START_CAL, 0));
        directed_rows.push_back(item_row(ACT_SAMPLE, 0));

        // Reset is held low from the start and released on a falling edge.
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_REG)
            begin
                wait_idle();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
            end
            else
            begin
                send_item(directed_rows[i].item, directed_rows[i].typed,
                          directed_rows[i].want);
            end
        end

        // Random part: the first settings pin the register extremes, the
        // rest are drawn at random with mostly small hysteresis and deadband.
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0:       apply_setting(1, 1'b0, 0, 0, 0);
                1:       apply_setting(16383, 1'b1, 16383, 16383, 16383);
                2:       apply_setting(16383, 1'b1, 8191, 0, 0);
                3:       apply_setting(1023, 1'b1, 512, 2, 20);
                4:       apply_setting(16383, 1'b0, 0, 0, 0);
                default: apply_setting($urandom_range(1, 16383), 1'($urandom_range(0, 1)),
                                       $urandom_range(0, 16383), $urandom_range(0, 8),
                                       $urandom_range(0, 64));
            endcase
            run_random_traffic(PHASE_ITEMS);
        end

        // Drain, then allow time for any stray result to show up.
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_results.size()));

        $display("Sent %0d items under %0d register settings; %0d samples were mapped,",
                 items_sent, settings_used, samples_mapped);
        $display("%0d moved the held value and %0d widened the span; %0d results checked.",
                 held_updates, span_widenings, results_seen);

        if (mismatches == 0)
            $display("calibrated_analog_mapper_core verification clean");
        else
            $display("calibrated_analog_mapper_core verification failed");
        $finish;
    end

endmodule
